// ===== rtl/tlca_pkg.sv =====
// Shared types and constants for the binary-lifting LCA engine.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package tlca_pkg;

    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;

    localparam int NODE_W  = $clog2(MAX_NODES);      // node number width
    localparam int DIST_W  = 32;                     // root distance / result width
    localparam int LVL_AW  = $clog2(LEVELS);         // level part of a table address
    localparam int CNT_W   = $clog2(LEVELS + 1);     // level counter, can hold LEVELS
    localparam int ANC_AW  = LVL_AW + NODE_W;        // ancestor table address
    localparam int ANC_DEP = LEVELS * MAX_NODES;     // ancestor table depth
    localparam int LEN_W   = NODE_W + 3;             // signed path-length arithmetic

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_DIST  = 2'd2,
        OP_KTH   = 2'd3
    } t_op;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BLD_A,
        S_BLD_B,
        S_BLD_C,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_ORD,
        S_LIFT,
        S_LIFT_CAP,
        S_MEET_RD,
        S_MEET_CMP,
        S_PAR_RD,
        S_PAR_CAP,
        S_P_RD,
        S_P_CAP,
        S_EVAL,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/tlca_req_if.sv =====
// Request channel of the LCA engine: valid/ready handshake and request fields.
// Depends on tlca_pkg.
`default_nettype none

interface tlca_req_if;
    logic                       valid;
    logic                       ready;
    tlca_pkg::t_op              op;
    logic [tlca_pkg::NODE_W-1:0] node_a;
    logic [tlca_pkg::NODE_W-1:0] node_b;
    logic [tlca_pkg::NODE_W-1:0] node_depth;
    logic [tlca_pkg::DIST_W-1:0] node_dist;
    logic [tlca_pkg::NODE_W-1:0] position;

    modport source (
        output valid, op, node_a, node_b, node_depth, node_dist, position,
        input  ready
    );
    modport sink (
        input  valid, op, node_a, node_b, node_depth, node_dist, position,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tlca_rsp_if.sv =====
// Response channel of the LCA engine: valid/ready handshake and result fields.
// Depends on tlca_pkg.
`default_nettype none

interface tlca_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tlca_pkg::DIST_W-1:0] result_value;
    logic                        status;

    modport source (
        output valid, result_value, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tree_lca_binary_lifting.sv =====
// Binary-lifting lowest-common-ancestor engine, top level.
// Depends on tlca_pkg, tlca_req_if and tlca_rsp_if.
`default_nettype none

// The host first loads every node (op 0: node number, parent, depth, root
// distance), writes node_count, then issues one build request (op 1) that fills
// jump-table levels 1..LEVELS-1 from level 0. Distance (op 2) and kth-node
// (op 3) queries then return one response each; loads and builds return none.
// Node 0 stands for "no node" and always reads as depth 0, distance 0, with no
// ancestors. The engine handles one request at a time through a small sequencer
// around a single ancestor-table memory (one write port, two registered read
// ports), so i_req.ready is high only while idle. A load is written to the
// memories as it is accepted. A build takes every node of every level
// through the read-read-write chain through the table. A query accepts the
// request and fetches both depths, equalizes depth with one table read per
// set bit of the depth difference, lifts both endpoints together from the
// top level down when they still differ, fetches the ancestor and its data
// and evaluates, for a kth query does a final lift, and loads the output
// register; dependent table reads dominate. A finished result waits in an
// output register, so the next request is taken while it is pending; a
// second result waits until the first is taken.
module tree_lca_binary_lifting (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tlca_pkg::NODE_W-1:0]   i_cfg_wdata,
    tlca_req_if.sink                           i_req,
    tlca_rsp_if.source                         o_rsp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tlca_pkg::t_state              r_state, n_state;
    tlca_pkg::t_op                 r_op, n_op;
    logic [tlca_pkg::NODE_W-1:0]   r_node_count;
    logic [tlca_pkg::NODE_W-1:0]   r_a, n_a;          // request endpoint u
    logic [tlca_pkg::NODE_W-1:0]   r_b, n_b;          // request endpoint v
    logic [tlca_pkg::NODE_W-1:0]   r_pos, n_pos;
    logic [tlca_pkg::NODE_W-1:0]   r_u, n_u;          // shallow walker
    logic [tlca_pkg::NODE_W-1:0]   r_v, n_v;          // deep walker / lift node
    logic [tlca_pkg::NODE_W-1:0]   r_p, n_p;          // common ancestor
    logic [tlca_pkg::LEVELS-1:0]   r_steps, n_steps;  // lift distance
    logic [tlca_pkg::CNT_W-1:0]    r_k, n_k;          // level counter
    logic                          r_ret_kth, n_ret_kth;
    logic [tlca_pkg::NODE_W-1:0]   r_idx, n_idx;      // build node counter
    logic [tlca_pkg::NODE_W-1:0]   r_dep_a, n_dep_a;
    logic [tlca_pkg::NODE_W-1:0]   r_dep_b, n_dep_b;
    logic [tlca_pkg::NODE_W-1:0]   r_dep_p, n_dep_p;
    logic [tlca_pkg::DIST_W-1:0]   r_dist_a, n_dist_a;
    logic [tlca_pkg::DIST_W-1:0]   r_dist_b, n_dist_b;
    logic [tlca_pkg::DIST_W-1:0]   r_dist_p, n_dist_p;
    logic [tlca_pkg::DIST_W-1:0]   r_res_value, n_res_value;   // finished answer
    logic                          r_res_status, n_res_status;
    logic                          r_out_valid, n_out_valid;
    logic [tlca_pkg::DIST_W-1:0]   r_out_value, n_out_value;
    logic                          r_out_status, n_out_status;

    // ------------------------------------------------------------------
    // Memories: ancestor table addressed {level, node}, node data store
    // ------------------------------------------------------------------
    logic [tlca_pkg::NODE_W-1:0]   anc_mem [tlca_pkg::ANC_DEP];
    logic [tlca_pkg::NODE_W-1:0]   dep_mem [tlca_pkg::MAX_NODES];
    logic [tlca_pkg::DIST_W-1:0]   dist_mem [tlca_pkg::MAX_NODES];

    logic [tlca_pkg::LVL_AW-1:0]   anc_lvl_a, anc_lvl_b, anc_wlvl;
    logic [tlca_pkg::NODE_W-1:0]   anc_node_a, anc_node_b, anc_wnode, anc_wdata;
    logic                          anc_we;
    logic [tlca_pkg::NODE_W-1:0]   nd_addr;
    logic                          nd_we;

    logic [tlca_pkg::NODE_W-1:0]   r_anc_qa, r_anc_qb, r_dep_q;
    logic [tlca_pkg::DIST_W-1:0]   r_dist_q;
    logic                          r_za, r_zb, r_zn;  // read was of node 0
    logic [tlca_pkg::NODE_W-1:0]   anc_qa, anc_qb, dep_q;
    logic [tlca_pkg::DIST_W-1:0]   dist_q;

    logic                          req_acc;
    logic                          rsp_acc;

    // Evaluation arithmetic
    logic signed [tlca_pkg::LEN_W-1:0] s_da, s_db, s_dp, s_w, s_len, s_x, s_tail;
    logic                          kth_bad;
    logic                          kth_from_a;
    logic [tlca_pkg::DIST_W-1:0]   dist_res;

    assign req_acc = i_req.valid && i_req.ready;
    assign rsp_acc = o_rsp.valid && o_rsp.ready;

    assign i_req.ready        = (r_state == tlca_pkg::S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;

    // Node 0 is "none": mask whatever the memory holds for it.
    assign anc_qa = r_za ? '0 : r_anc_qa;
    assign anc_qb = r_zb ? '0 : r_anc_qb;
    assign dep_q  = r_zn ? '0 : r_dep_q;
    assign dist_q = r_zn ? '0 : r_dist_q;

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            anc_mem[{anc_wlvl, anc_wnode}] <= anc_wdata;
        end
        r_anc_qa <= anc_mem[{anc_lvl_a, anc_node_a}];
        r_anc_qb <= anc_mem[{anc_lvl_b, anc_node_b}];
        r_za     <= (anc_node_a == '0);
        r_zb     <= (anc_node_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            dep_mem[i_req.node_a]  <= i_req.node_depth;
            dist_mem[i_req.node_a] <= i_req.node_dist;
        end
        r_dep_q  <= dep_mem[nd_addr];
        r_dist_q <= dist_mem[nd_addr];
        r_zn     <= (nd_addr == '0);
    end

    // ------------------------------------------------------------------
    // Query evaluation: path length, split point, distance
    // ------------------------------------------------------------------
    always_comb begin
        s_da   = $signed({{(tlca_pkg::LEN_W - tlca_pkg::NODE_W){1'b0}}, r_dep_a});
        s_db   = $signed({{(tlca_pkg::LEN_W - tlca_pkg::NODE_W){1'b0}}, r_dep_b});
        s_dp   = $signed({{(tlca_pkg::LEN_W - tlca_pkg::NODE_W){1'b0}}, r_dep_p});
        s_w    = $signed({{(tlca_pkg::LEN_W - tlca_pkg::NODE_W){1'b0}}, r_pos});
        s_len  = s_da + s_db - (s_dp + s_dp) + $signed(tlca_pkg::LEN_W'(1));
        s_x    = s_da - s_dp;
        s_tail = s_len - s_w;
        kth_bad    = (r_pos == '0) || (s_w > s_len);
        kth_from_a = (s_x + $signed(tlca_pkg::LEN_W'(1))) >= s_w;
        dist_res   = r_dist_a + r_dist_b - {r_dist_p[tlca_pkg::DIST_W-2:0], 1'b0};
    end

    // ------------------------------------------------------------------
    // Memory addressing and writes per state
    // ------------------------------------------------------------------
    always_comb begin
        anc_lvl_a  = '0;
        anc_node_a = '0;
        anc_lvl_b  = '0;
        anc_node_b = '0;
        anc_we     = 1'b0;
        anc_wlvl   = '0;
        anc_wnode  = i_req.node_a;
        anc_wdata  = i_req.node_b;
        nd_addr    = r_a;
        nd_we      = 1'b0;
        case (r_state)
            tlca_pkg::S_IDLE: begin
                // loads write level 0 and node data; node 0 stays fixed
                if (req_acc && i_req.op == tlca_pkg::OP_LOAD && i_req.node_a != '0) begin
                    anc_we = 1'b1;
                    nd_we  = 1'b1;
                end
            end
            tlca_pkg::S_BLD_A: begin
                anc_lvl_a  = r_k[tlca_pkg::LVL_AW-1:0];
                anc_node_a = r_idx;
            end
            tlca_pkg::S_BLD_B: begin
                anc_lvl_a  = r_k[tlca_pkg::LVL_AW-1:0];
                anc_node_a = anc_qa;
            end
            tlca_pkg::S_BLD_C: begin
                anc_we    = 1'b1;
                anc_wlvl  = r_k[tlca_pkg::LVL_AW-1:0] + tlca_pkg::LVL_AW'(1);
                anc_wnode = r_idx;
                anc_wdata = anc_qa;
            end
            tlca_pkg::S_Q_RDA: nd_addr = r_a;
            tlca_pkg::S_Q_RDB: nd_addr = r_b;
            tlca_pkg::S_LIFT: begin
                anc_lvl_a  = r_k[tlca_pkg::LVL_AW-1:0];
                anc_node_a = r_v;
            end
            tlca_pkg::S_MEET_RD: begin
                anc_lvl_a  = r_k[tlca_pkg::LVL_AW-1:0];
                anc_node_a = r_u;
                anc_lvl_b  = r_k[tlca_pkg::LVL_AW-1:0];
                anc_node_b = r_v;
            end
            tlca_pkg::S_PAR_RD: anc_node_a = r_u;
            tlca_pkg::S_P_RD:   nd_addr = r_p;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and next register values
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_a          = r_a;
        n_b          = r_b;
        n_pos        = r_pos;
        n_u          = r_u;
        n_v          = r_v;
        n_p          = r_p;
        n_steps      = r_steps;
        n_k          = r_k;
        n_ret_kth    = r_ret_kth;
        n_idx        = r_idx;
        n_dep_a      = r_dep_a;
        n_dep_b      = r_dep_b;
        n_dep_p      = r_dep_p;
        n_dist_a     = r_dist_a;
        n_dist_b     = r_dist_b;
        n_dist_p     = r_dist_p;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !rsp_acc;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        case (r_state)
            tlca_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_op  = i_req.op;
                    n_a   = i_req.node_a;
                    n_b   = i_req.node_b;
                    n_pos = i_req.position;
                    n_k   = '0;
                    n_idx = tlca_pkg::NODE_W'(1);
                    case (i_req.op)
                        tlca_pkg::OP_LOAD:  n_state = tlca_pkg::S_IDLE;
                        tlca_pkg::OP_BUILD: begin
                            // nothing to build without nodes
                            n_state = (r_node_count == '0) ? tlca_pkg::S_IDLE
                                                           : tlca_pkg::S_BLD_A;
                        end
                        default:            n_state = tlca_pkg::S_Q_RDA;
                    endcase
                end
            end

            // Build: level k+1 of node i is level k of level k of node i.
            tlca_pkg::S_BLD_A: n_state = tlca_pkg::S_BLD_B;
            tlca_pkg::S_BLD_B: n_state = tlca_pkg::S_BLD_C;
            tlca_pkg::S_BLD_C: begin
                n_state = tlca_pkg::S_BLD_A;
                if (r_idx == r_node_count) begin
                    n_idx = tlca_pkg::NODE_W'(1);
                    if (r_k == tlca_pkg::CNT_W'(tlca_pkg::LEVELS - 2)) begin
                        n_state = tlca_pkg::S_IDLE;
                    end else begin
                        n_k = r_k + tlca_pkg::CNT_W'(1);
                    end
                end else begin
                    n_idx = r_idx + tlca_pkg::NODE_W'(1);
                end
            end

            // Query: fetch depth and distance of both endpoints.
            tlca_pkg::S_Q_RDA: n_state = tlca_pkg::S_Q_RDB;
            tlca_pkg::S_Q_RDB: begin
                n_dep_a  = dep_q;
                n_dist_a = dist_q;
                n_state  = tlca_pkg::S_Q_ORD;
            end
            tlca_pkg::S_Q_ORD: begin
                n_dep_b   = dep_q;
                n_dist_b  = dist_q;
                n_k       = '0;
                n_ret_kth = 1'b0;
                // put the deeper endpoint in the lift walker
                if (r_dep_a > dep_q) begin
                    n_u     = r_b;
                    n_v     = r_a;
                    n_steps = tlca_pkg::LEVELS'(r_dep_a - dep_q);
                end else begin
                    n_u     = r_a;
                    n_v     = r_b;
                    n_steps = tlca_pkg::LEVELS'(dep_q - r_dep_a);
                end
                n_state = tlca_pkg::S_LIFT;
            end

            // Lift r_v by r_steps, one table read per set bit.
            tlca_pkg::S_LIFT: begin
                if (r_k == tlca_pkg::CNT_W'(tlca_pkg::LEVELS)) begin
                    if (r_ret_kth) begin
                        n_res_value  = tlca_pkg::DIST_W'(r_v);
                        n_res_status = tlca_pkg::STAT_OK;
                        n_state      = tlca_pkg::S_OUT;
                    end else if (r_u == r_v) begin
                        n_p     = r_u;
                        n_state = tlca_pkg::S_P_RD;
                    end else begin
                        n_k     = tlca_pkg::CNT_W'(tlca_pkg::LEVELS - 1);
                        n_state = tlca_pkg::S_MEET_RD;
                    end
                end else if (r_steps[r_k[tlca_pkg::LVL_AW-1:0]]) begin
                    n_state = tlca_pkg::S_LIFT_CAP;
                end else begin
                    n_k = r_k + tlca_pkg::CNT_W'(1);
                end
            end
            tlca_pkg::S_LIFT_CAP: begin
                n_v     = anc_qa;
                n_k     = r_k + tlca_pkg::CNT_W'(1);
                n_state = tlca_pkg::S_LIFT;
            end

            // Lift both walkers while their ancestors differ, top level down.
            tlca_pkg::S_MEET_RD: n_state = tlca_pkg::S_MEET_CMP;
            tlca_pkg::S_MEET_CMP: begin
                if (anc_qa != anc_qb) begin
                    n_u = anc_qa;
                    n_v = anc_qb;
                end
                if (r_k == '0) begin
                    n_state = tlca_pkg::S_PAR_RD;
                end else begin
                    n_k     = r_k - tlca_pkg::CNT_W'(1);
                    n_state = tlca_pkg::S_MEET_RD;
                end
            end
            tlca_pkg::S_PAR_RD:  n_state = tlca_pkg::S_PAR_CAP;
            tlca_pkg::S_PAR_CAP: begin
                n_p     = anc_qa;
                n_state = tlca_pkg::S_P_RD;
            end

            // Fetch the common ancestor's data, then evaluate.
            tlca_pkg::S_P_RD:  n_state = tlca_pkg::S_P_CAP;
            tlca_pkg::S_P_CAP: begin
                n_dep_p  = dep_q;
                n_dist_p = dist_q;
                n_state  = tlca_pkg::S_EVAL;
            end
            tlca_pkg::S_EVAL: begin
                if (r_op == tlca_pkg::OP_DIST) begin
                    n_res_value  = dist_res;
                    n_res_status = tlca_pkg::STAT_OK;
                    n_state      = tlca_pkg::S_OUT;
                end else if (kth_bad) begin
                    n_res_value  = '0;
                    n_res_status = tlca_pkg::STAT_RANGE;
                    n_state      = tlca_pkg::S_OUT;
                end else begin
                    // walk up from u for the first leg, from v for the second
                    n_k       = '0;
                    n_ret_kth = 1'b1;
                    if (kth_from_a) begin
                        n_v     = r_a;
                        n_steps = tlca_pkg::LEVELS'(r_pos - tlca_pkg::NODE_W'(1));
                    end else begin
                        n_v     = r_b;
                        n_steps = s_tail[tlca_pkg::LEVELS-1:0];
                    end
                    n_state = tlca_pkg::S_LIFT;
                end
            end

            // Hold the result until the output register is free.
            tlca_pkg::S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = tlca_pkg::S_IDLE;
                end
            end

            default: n_state = tlca_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tlca_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_node_count <= tlca_pkg::NODE_W'(1);
            r_k          <= '0;
            r_idx        <= tlca_pkg::NODE_W'(1);
            r_ret_kth    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_ret_kth   <= n_ret_kth;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_pos        <= n_pos;
        r_u          <= n_u;
        r_v          <= n_v;
        r_p          <= n_p;
        r_steps      <= n_steps;
        r_dep_a      <= n_dep_a;
        r_dep_b      <= n_dep_b;
        r_dep_p      <= n_dep_p;
        r_dist_a     <= n_dist_a;
        r_dist_b     <= n_dist_b;
        r_dist_p     <= n_dist_p;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_req.op == tlca_pkg::OP_DIST || i_req.op == tlca_pkg::OP_KTH))
        |=> (r_state == tlca_pkg::S_Q_RDA))
        else $error("query did not start the depth fetch");

    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlca_pkg::S_BLD_A || r_state == tlca_pkg::S_BLD_B ||
         r_state == tlca_pkg::S_BLD_C)
        |-> (r_k <= tlca_pkg::CNT_W'(tlca_pkg::LEVELS - 2) && r_idx != '0))
        else $error("build counters out of range");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlca_pkg::S_OUT && (!r_out_valid || o_rsp.ready))
        |=> (r_out_valid && r_state == tlca_pkg::S_IDLE))
        else $error("finished result not loaded into output register");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == tlca_pkg::STAT_RANGE)
        |-> (o_rsp.result_value == '0))
        else $error("range error with nonzero value");

    a_meet_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlca_pkg::S_MEET_RD) |-> (r_k < tlca_pkg::CNT_W'(tlca_pkg::LEVELS)))
        else $error("common lift level out of range");

endmodule

`default_nettype wire
